### rtl/core/sfm_pkg.sv
// ---------------------------------------------------------------------------
// sfm_pkg
// Shared codes, field widths and cell control type for the substring search.
// ---------------------------------------------------------------------------
package sfm_pkg;

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int POS_OUT_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_END     = 2'd2,
    OP_UNUSED  = 2'd3
  } sfm_op_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic              load;       // write data_byte into the cell at the write pointer
    logic              shift;      // text item: advance the partial-match chain
    logic              clear;      // drop all partial matches
    logic [BYTE_W-1:0] data_byte;
  } sfm_cell_ctrl_t;

endpackage

### rtl/core/sfm_in_if.sv
// ---------------------------------------------------------------------------
// sfm_in_if
// Input item channel: op code and data byte under valid/ready.
// ---------------------------------------------------------------------------
interface sfm_in_if
  import sfm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

### rtl/core/sfm_out_if.sv
// ---------------------------------------------------------------------------
// sfm_out_if
// Result item channel: search outcome under valid/ready.
// ---------------------------------------------------------------------------
interface sfm_out_if
  import sfm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [POS_OUT_W-1:0] match_position;
  logic                 pattern_too_long;

  modport source (output valid, output found, output match_position,
                  output pattern_too_long, input ready);
  modport sink   (input valid, input found, input match_position,
                  input pattern_too_long, output ready);
endinterface

### rtl/core/sfm_cell.sv
// ---------------------------------------------------------------------------
// sfm_cell
// One pattern cell: holds a pattern byte and its partial-match bit.
// ---------------------------------------------------------------------------
module sfm_cell
  import sfm_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int LEN_W = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  sfm_cell_ctrl_t ctrl,
  input  logic [LEN_W-1:0] wr_ptr,
  input  logic [LEN_W-1:0] length,
  input  logic           prev_match,
  output logic           match,
  output logic           hit
);

  localparam logic [LEN_W-1:0] MY_POS  = LEN_W'(INDEX);
  localparam logic [LEN_W-1:0] MY_LAST = LEN_W'(INDEX + 1);

  logic [BYTE_W-1:0] pat_byte;
  logic              in_use;
  logic              match_next;

  assign in_use     = (MY_POS < length);
  assign match_next = prev_match & in_use & (pat_byte == ctrl.data_byte);
  // this cell closes the pattern: a full match ends here
  assign hit        = match_next & (length == MY_LAST);

  always_ff @(posedge clk) begin
    if (ctrl.load && (wr_ptr == MY_POS)) begin
      pat_byte <= ctrl.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.shift) begin
      match <= match_next;
    end
  end

endmodule

### rtl/core/substring_first_match_search_unit.sv
// ---------------------------------------------------------------------------
// substring_first_match_search_unit
// Streaming first-occurrence substring search over a row of pattern cells.
// ---------------------------------------------------------------------------
//
//  channel  dir  carries                                       handshake
//  in_ch    in   op, data_byte                                 valid/ready
//  out_ch   out  found, match_position, pattern_too_long       valid/ready
//
//  One item per cycle is sustained while in_ch does not stall. All cells
//  compare the text byte in the same cycle, so the cell row sets the rate.
//  Reset (rst, synchronous) empties the pattern and the text state.
//  An end item loads the result register; in_ch stalls only while that
//  register is full and out_ch does not take it.
//
module substring_first_match_search_unit
  import sfm_pkg::*;
#(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  sfm_in_if.sink    in_ch,
  sfm_out_if.source out_ch
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0]         LEN_MAX = LEN_W'(MAX_PATTERN);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // pattern state
  logic [LEN_W-1:0] length;
  logic             overflow;
  logic             start_new;

  // text state
  logic [POSITION_BITS-1:0] text_count;
  logic                     match_seen;
  logic [POSITION_BITS-1:0] first_start;

  // result register
  logic                 out_valid;
  logic                 out_found;
  logic [POS_OUT_W-1:0] out_pos;
  logic                 out_too_long;

  logic in_fire, is_pat, is_text, is_end;
  logic [LEN_W-1:0] eff_len;
  logic             room;
  sfm_cell_ctrl_t   ctrl;

  logic [MAX_PATTERN-1:0] match_vec;
  logic [MAX_PATTERN-1:0] hit_vec;
  logic                   hit_any;

  logic                          report_pos;
  logic [POSITION_BITS+POS_OUT_W-1:0] first_wide;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_pat      = in_fire && (in_ch.op == OP_PATTERN);
  assign is_text     = in_fire && (in_ch.op == OP_TEXT);
  assign is_end      = in_fire && (in_ch.op == OP_END);

  // first pattern byte after an end item restarts the pattern at cell 0
  assign eff_len = start_new ? '0 : length;
  assign room    = (eff_len < LEN_MAX);

  always_comb begin
    ctrl.load      = is_pat && room;
    ctrl.shift     = is_text;
    ctrl.clear     = is_pat || is_end;
    ctrl.data_byte = in_ch.data_byte;
  end

  // cell row: partial-match bits ripple one cell per text item
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b1;   // a match may start at every text byte
    end else begin : g_link
      assign prev = match_vec[i-1];
    end
    sfm_cell #(
      .INDEX (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .wr_ptr     (eff_len),
      .length     (length),
      .prev_match (prev),
      .match      (match_vec[i]),
      .hit        (hit_vec[i])
    );
  end

  assign hit_any = |hit_vec;

  // pattern registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      overflow  <= 1'b0;
      start_new <= 1'b1;
    end else if (is_pat) begin
      start_new <= 1'b0;
      if (room) begin
        length   <= eff_len + LEN_W'(1);
        overflow <= start_new ? 1'b0 : overflow;
      end else begin
        length   <= eff_len;
        overflow <= 1'b1;
      end
    end else if (is_end) begin
      start_new <= 1'b1;
    end
  end

  // text registers; the first match is held, the count saturates
  always_ff @(posedge clk) begin
    if (rst || is_pat || is_end) begin
      text_count  <= '0;
      match_seen  <= 1'b0;
      first_start <= '0;
    end else if (is_text) begin
      if (!match_seen && (length != '0) && !overflow && hit_any) begin
        match_seen  <= 1'b1;
        // start = count - (length - 1)
        first_start <= text_count - POSITION_BITS'(length) + POSITION_BITS'(1);
      end
      if (text_count != POS_MAX) begin
        text_count <= text_count + POSITION_BITS'(1);
      end
    end
  end

  // result fields; position cut to the 32-bit port
  assign report_pos = !overflow && (length != '0) && match_seen;
  assign first_wide = {{POS_OUT_W{1'b0}}, first_start};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_end) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_end) begin
      out_found    <= !overflow && ((length == '0) || match_seen);
      out_pos      <= report_pos ? first_wide[POS_OUT_W-1:0] : '0;
      out_too_long <= overflow;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.found            = out_found;
  assign out_ch.match_position   = out_pos;
  assign out_ch.pattern_too_long = out_too_long;

endmodule

### test/tb_substring_first_match_search_unit.sv
// ---------------------------------------------------------------------------
// tb_substring_first_match_search_unit
// Self-checking bench for the streaming substring search. Pattern, text and
// end items go in under random bursts and gaps; a behavioral matcher in the
// bench predicts every report, and each report leaving the block is checked
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_substring_first_match_search_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sfm_pkg::*;

  // The block runs with its default sizes: 64 pattern cells and a 32-bit
  // text position.
  localparam int     MAX_PAT      = 64;
  localparam int     POS_BITS     = 32;
  localparam longint POS_MAX      = (longint'(1) << POS_BITS) - 1;
  localparam int     RANDOM_ITEMS = 975;
  localparam int     CYCLE_LIMIT  = 300000;
  localparam int     SETTLE       = 8;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct {
    bit                   found;
    logic [POS_OUT_W-1:0] position;
    bit                   too_long;
  } search_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;

  sfm_in_if  in_ch();
  sfm_out_if out_ch();

  assign out_ch.ready = sink_ready;

  substring_first_match_search_unit #(
    .MAX_PATTERN  (MAX_PAT),
    .POSITION_BITS(POS_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Matcher state mirrored in the bench
  // -------------------------------------------------------------------------
  logic [BYTE_W-1:0]  pat_bytes [MAX_PAT];
  int                 pat_len       = 0;
  bit                 pat_overflow  = 1'b0;
  bit                 pat_fresh     = 1'b1;  // next pattern byte starts over
  logic [MAX_PAT-1:0] live_prefixes = '0;    // bit i: last i+1 bytes = pattern 0..i
  longint             text_pos      = 0;
  bit                 hit_seen      = 1'b0;
  longint             hit_start     = 0;

  search_report_t expected_reports[$];
  search_report_t oldest_report;
  int             error_count = 0;
  int             items_sent  = 0;

  // sender pacing
  int burst_left = 0;
  int gap_max    = 6;

  // current pattern and its byte alphabet, kept so texts can be searched again
  byte_q_t           cur_pattern;
  logic [BYTE_W-1:0] cur_base = '0;

  function automatic void restart_text();
    live_prefixes = '0;
    text_pos      = 0;
    hit_seen      = 1'b0;
    hit_start     = 0;
  endfunction

  // Apply one accepted item to the mirrored matcher; an end item queues the
  // report the block must give.
  task automatic advance_search(sfm_op_t op, logic [BYTE_W-1:0] b);
    logic [MAX_PAT-1:0] eq;
    search_report_t     rep;
    int                 i;
    case (op)
      OP_PATTERN: begin
        if (pat_fresh) begin
          pat_len      = 0;
          pat_overflow = 1'b0;
          pat_fresh    = 1'b0;
        end
        restart_text();
        if (pat_len < MAX_PAT) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
      end
      OP_TEXT: begin
        eq = '0;
        for (i = 0; i < pat_len; i++)
          if (pat_bytes[i] == b) eq[i] = 1'b1;
        // every byte may open a new partial match at cell 0
        live_prefixes = {live_prefixes[MAX_PAT-2:0], 1'b1} & eq;
        if (!hit_seen && pat_len > 0 && !pat_overflow && live_prefixes[pat_len-1]) begin
          hit_seen  = 1'b1;
          hit_start = text_pos - (pat_len - 1);
        end
        if (text_pos < POS_MAX) text_pos++;
      end
      OP_END: begin
        rep.found    = !pat_overflow && (pat_len == 0 || hit_seen);
        rep.position = (!pat_overflow && pat_len != 0 && hit_seen) ? hit_start[31:0] : '0;
        rep.too_long = pat_overflow;
        expected_reports.push_back(rep);
        restart_text();
        pat_fresh = 1'b1;
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Item driver
  // -------------------------------------------------------------------------
  // Holds valid through a burst; at the end of a burst drops it for a random
  // gap. Returns in the time step of the accepting edge.
  task automatic send_item(sfm_op_t op, logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    advance_search(op, b);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_bytes(sfm_op_t op, byte_q_t bytes);
    foreach (bytes[k]) send_item(op, bytes[k]);
  endtask

  task automatic end_search();
    send_item(OP_END, 8'($urandom_range(0, 255)));
  endtask

  // Stop sending until every queued report has come out.
  task automatic wait_all_reports();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk);
    end while (expected_reports.size() != 0);
  endtask

  // -------------------------------------------------------------------------
  // Receiver stalls, cycle limit
  // -------------------------------------------------------------------------
  // The stall mode changes whenever the low byte of cycle_count is zero:
  // always ready, coin flip, one cycle in four, or mostly ready.
  int       cycle_count = 0;
  bit [1:0] stall_mode  = 2'd0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: sink_ready <= 1'b1;
      2'd1: sink_ready <= 1'($urandom_range(0, 1));
      2'd2: sink_ready <= (cycle_count[1:0] == 2'd3);
      default: sink_ready <= ($urandom_range(0, 6) != 0);
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d reports pending", $time,
               expected_reports.size());
      $display("tb_substring_first_match_search_unit: done, errors");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Report checker
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, got found %0b pos %0d too_long %0b",
                 $time, out_ch.found, out_ch.match_position, out_ch.pattern_too_long);
        error_count++;
      end else begin
        oldest_report = expected_reports.pop_front();
        if (out_ch.found !== oldest_report.found) begin
          $display("%0t: found: expected %0b, got %0b", $time,
                   oldest_report.found, out_ch.found);
          error_count++;
        end
        if (out_ch.match_position !== oldest_report.position) begin
          $display("%0t: match_position: expected %0d, got %0d", $time,
                   oldest_report.position, out_ch.match_position);
          error_count++;
        end
        if (out_ch.pattern_too_long !== oldest_report.too_long) begin
          $display("%0t: pattern_too_long: expected %0b, got %0b", $time,
                   oldest_report.too_long, out_ch.pattern_too_long);
          error_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // No pattern loaded yet: the empty pattern matches at 0, with or without
  // text. The unused op code must pass without a trace.
  task automatic test_empty_pattern();
    end_search();
    send_item(OP_TEXT, 8'h00);
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_TEXT, 8'hFF);
    end_search();
  endtask

  task automatic test_directed_matches();
    // extreme byte values, text goes on after the first match
    send_bytes(OP_PATTERN, '{8'h00, 8'hFF});
    send_bytes(OP_TEXT, '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    end_search();
    // same pattern, new text with no occurrence
    send_bytes(OP_TEXT, '{8'h00, 8'h00});
    end_search();
    // pattern byte among text bytes: pattern grows, search restarts
    send_bytes(OP_PATTERN, '{8'h41, 8'h42});
    send_item(OP_TEXT, 8'h41);
    send_item(OP_PATTERN, 8'h43);
    send_bytes(OP_TEXT, '{8'h41, 8'h42, 8'h43});
    end_search();
    // self-overlapping prefix
    send_bytes(OP_PATTERN, '{8'h61, 8'h61, 8'h62});
    send_bytes(OP_TEXT, '{8'h61, 8'h61, 8'h61, 8'h62});
    end_search();
    wait_all_reports();
  endtask

  // Patterns at and beyond the store depth; the overflow flag survives an
  // end item until a new pattern begins.
  task automatic test_overlong_pattern();
    byte_q_t pat;
    int      i;
    for (i = 0; i < MAX_PAT + 1; i++) pat.push_back(8'($urandom_range(0, 255)));
    send_bytes(OP_PATTERN, pat);
    send_bytes(OP_TEXT, pat);
    end_search();
    send_bytes(OP_TEXT, '{8'h5A, 8'hA5});
    end_search();
    // exactly full store, found in the text
    pat.delete(MAX_PAT);
    send_bytes(OP_PATTERN, pat);
    send_item(OP_TEXT, 8'h00);
    send_bytes(OP_TEXT, pat);
    end_search();
    for (i = 0; i < 6; i++) pat.push_back(8'($urandom_range(0, 255)));
    send_bytes(OP_PATTERN, pat);
    end_search();
    // a short pattern clears the flag
    send_item(OP_PATTERN, 8'h7E);
    send_bytes(OP_TEXT, '{8'h00, 8'h7E});
    end_search();
  endtask

  // Matches that start well into a long text, with more text after them.
  task automatic test_long_texts();
    byte_q_t pat;
    int      i;
    pat = '{8'hA5, 8'h5A, 8'hC3};
    send_bytes(OP_PATTERN, pat);
    repeat (40) send_item(OP_TEXT, 8'h00);
    send_bytes(OP_TEXT, pat);
    end_search();
    // full-length pattern deep in the text, then more text
    pat = {};
    for (i = 0; i < MAX_PAT; i++) pat.push_back(8'h80 | 8'(i));
    send_bytes(OP_PATTERN, pat);
    repeat (20) send_item(OP_TEXT, 8'h00);
    send_bytes(OP_TEXT, pat);
    repeat (10) send_item(OP_TEXT, 8'h80);
    end_search();
    wait_all_reports();
  endtask

  // Mostly well-formed searches over a four-byte alphabet with the pattern
  // planted half the time; some reuse the previous pattern, some get a
  // pattern byte in mid-text, and a few items are plain noise.
  task automatic test_random_searches();
    byte_q_t           text;
    logic [BYTE_W-1:0] extra;
    int                start_count, kind, len, text_len, at, split_at, i;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 99);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (kind < 8) begin
        send_item(sfm_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        if (kind >= 20 || cur_pattern.size() == 0) begin
          kind     = $urandom_range(0, 99);
          len      = (kind < 85) ? $urandom_range(1, 6) :
                     (kind < 95) ? $urandom_range(7, MAX_PAT) :
                                   $urandom_range(MAX_PAT + 1, MAX_PAT + 6);
          cur_base = 8'($urandom_range(0, 255));
          cur_pattern = {};
          for (i = 0; i < len; i++) cur_pattern.push_back(cur_base ^ 8'($urandom_range(0, 3)));
          send_bytes(OP_PATTERN, cur_pattern);
        end
        text     = {};
        text_len = $urandom_range(0, 20);
        for (i = 0; i < text_len; i++) text.push_back(cur_base ^ 8'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 1) begin
          at = $urandom_range(0, text.size());
          foreach (cur_pattern[k]) text.insert(at + k, cur_pattern[k]);
        end
        split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, text.size()) : -1;
        for (i = 0; i <= text.size(); i++) begin
          if (i == split_at) begin
            extra = cur_base ^ 8'($urandom_range(0, 3));
            send_item(OP_PATTERN, extra);
            cur_pattern.push_back(extra);
          end
          if (i < text.size()) send_item(OP_TEXT, text[i]);
        end
        end_search();
        if ($urandom_range(0, 49) == 0) wait_all_reports();
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_PATTERN;
    in_ch.data_byte <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_directed_matches();
    test_overlong_pattern();
    test_long_texts();
    test_random_searches();

    wait_all_reports();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_substring_first_match_search_unit: done, clean");
    end else begin
      $display("tb_substring_first_match_search_unit: done, errors");
    end
    $finish;
  end

endmodule
